// File: sv/invite_frame_checker_defines.svh
// Assertion macros shared by the invite frame checker verification files.
// Depends on nothing; included by the port checker.
`ifndef INVITE_FRAME_CHECKER_DEFINES_SVH
`define INVITE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ifc_pkg.sv
// Shared types, constants and the host character rule for the invite frame checker.
// Depends on nothing; used by the top level and the port checker.
package ifc_pkg;

    // Frame layout.
    localparam int HDR_BYTES     = 21;
    localparam int CALL_ID_SPLIT = 10;
    localparam int PORT_POS      = 18;
    localparam int HLEN_POS      = 20;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Configuration register indexes.
    localparam logic [7:0] REG_EXPECTED_VERSION   = 8'd0;
    localparam logic [7:0] REG_RESERVED_FLAG_MASK = 8'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_VERSION   = 3'd2,
        ST_RESERVED  = 3'd3,
        ST_ZERO_ID   = 3'd4,
        ST_LENGTH    = 3'd5,
        ST_HOST_CHAR = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_frame_in;

    typedef struct packed {
        logic        frame_done;
        t_status     status;
        logic [7:0]  flag_bits;
        logic [15:0] port_number;
        logic [7:0]  host_length;
        logic [63:0] call_id_high;
        logic [63:0] call_id_low;
        logic        is_host;
        logic [7:0]  host_char;
        logic [7:0]  host_position;
    } t_frame_out;

    typedef struct packed {
        logic [7:0] reg_index;
        logic [7:0] write_data;
    } t_cfg_write;

    function automatic logic legal_host_byte(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          CHAR_DOT, CHAR_DASH, CHAR_COLON});
    endfunction

endpackage

// File: sv/ifc_stream_if.sv
// Valid/ready channel carrying one request of a given payload type.
// Depends on nothing; the payload type comes from ifc_pkg at instantiation.
interface ifc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/invite_frame_checker.sv
// Invite frame checker: streaming decode and validation of one frame a byte at a time.
// Depends on ifc_pkg and ifc_stream_if.
//
// One frame byte is taken on i_frame each clock cycle and its result appears on
// o_result in the next cycle; throughput is one byte per cycle while results are taken
// as they come. The single result register holds one result: while it waits on
// o_result the input stalls, and a new byte is taken in the same cycle that the
// waiting result is taken.
// Every byte gives one result: host bytes are echoed with their index, and the byte
// marked last carries the verdict, the decoded header, and clears the frame state.
// Configuration writes on i_cfg are always accepted and should be made between frames.
module invite_frame_checker #(
    parameter int MAX_FRAME_BYTES = 276
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ifc_stream_if.sink   i_frame,
    ifc_stream_if.source o_result,
    ifc_stream_if.sink   i_cfg
);
    import ifc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

    t_frame_in  frame_in;
    t_cfg_write cfg_in;
    logic       frame_acc;

    // Configuration registers.
    logic [7:0] r_expected_version;
    logic [7:0] r_reserved_flag_mask;

    // Frame state.
    logic [CNT_W-1:0] r_byte_count,    n_byte_count,    upd_byte_count;
    logic             r_version_bad,   n_version_bad,   upd_version_bad;
    logic [7:0]       r_flags_held,    n_flags_held,    upd_flags_held;
    logic [63:0]      r_call_id_high,  n_call_id_high,  upd_call_id_high;
    logic [63:0]      r_call_id_low,   n_call_id_low,   upd_call_id_low;
    logic             r_call_id_nz,    n_call_id_nz,    upd_call_id_nz;
    logic [15:0]      r_port_held,     n_port_held,     upd_port_held;
    logic [7:0]       r_host_len_held, n_host_len_held, upd_host_len_held;
    logic             r_host_char_bad, n_host_char_bad, upd_host_char_bad;

    // Result register.
    logic       r_out_valid;
    t_frame_out r_out, n_out;

    logic [15:0] host_offset;
    logic        in_host;
    t_status     verdict;

    assign frame_in  = i_frame.payload;
    assign cfg_in    = i_cfg.payload;
    assign i_frame.ready = !r_out_valid || o_result.ready;
    assign frame_acc = i_frame.valid && i_frame.ready;
    assign i_cfg.ready = 1'b1;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    assign host_offset = 16'(r_byte_count) - 16'(HDR_BYTES);

    always_comb begin
        upd_byte_count    = r_byte_count;
        upd_version_bad   = r_version_bad;
        upd_flags_held    = r_flags_held;
        upd_call_id_high  = r_call_id_high;
        upd_call_id_low   = r_call_id_low;
        upd_call_id_nz    = r_call_id_nz;
        upd_port_held     = r_port_held;
        upd_host_len_held = r_host_len_held;
        upd_host_char_bad = r_host_char_bad;
        in_host           = 1'b0;

        // Once the counter passes the maximum, bytes are no longer decoded.
        if (r_byte_count <= CNT_W'(MAX_FRAME_BYTES)) begin
            if (r_byte_count == '0) begin
                upd_version_bad = frame_in.byte_value != r_expected_version;
            end else if (r_byte_count == CNT_W'(1)) begin
                upd_flags_held = frame_in.byte_value;
            end else if (r_byte_count < CNT_W'(CALL_ID_SPLIT)) begin
                upd_call_id_high = {r_call_id_high[55:0], frame_in.byte_value};
                if (frame_in.byte_value != 8'd0) begin
                    upd_call_id_nz = 1'b1;
                end
            end else if (r_byte_count < CNT_W'(PORT_POS)) begin
                upd_call_id_low = {r_call_id_low[55:0], frame_in.byte_value};
                if (frame_in.byte_value != 8'd0) begin
                    upd_call_id_nz = 1'b1;
                end
            end else if (r_byte_count < CNT_W'(HLEN_POS)) begin
                upd_port_held = {r_port_held[7:0], frame_in.byte_value};
            end else if (r_byte_count == CNT_W'(HLEN_POS)) begin
                upd_host_len_held = frame_in.byte_value;
            end else if (host_offset < 16'(r_host_len_held)) begin
                in_host = 1'b1;
                if (!legal_host_byte(frame_in.byte_value)) begin
                    upd_host_char_bad = 1'b1;
                end
            end
            upd_byte_count = r_byte_count + CNT_W'(1);
        end

        if (upd_byte_count < CNT_W'(HDR_BYTES)) begin
            verdict = ST_SHORT;
        end else if (upd_byte_count > CNT_W'(MAX_FRAME_BYTES)) begin
            verdict = ST_LENGTH;
        end else if (upd_version_bad) begin
            verdict = ST_VERSION;
        end else if ((upd_flags_held & r_reserved_flag_mask) != 8'd0) begin
            verdict = ST_RESERVED;
        end else if (!upd_call_id_nz) begin
            verdict = ST_ZERO_ID;
        end else if (16'(upd_byte_count) != 16'(HDR_BYTES) + 16'(upd_host_len_held)) begin
            verdict = ST_LENGTH;
        end else if (upd_host_char_bad) begin
            verdict = ST_HOST_CHAR;
        end else begin
            verdict = ST_OK;
        end

        n_out               = '0;
        n_out.is_host       = in_host;
        n_out.host_char     = in_host ? frame_in.byte_value : 8'd0;
        n_out.host_position = in_host ? host_offset[7:0] : 8'd0;
        if (frame_in.last_byte) begin
            n_out.frame_done   = 1'b1;
            n_out.status       = verdict;
            n_out.flag_bits    = upd_flags_held;
            n_out.port_number  = upd_port_held;
            n_out.host_length  = upd_host_len_held;
            n_out.call_id_high = upd_call_id_high;
            n_out.call_id_low  = upd_call_id_low;
        end else begin
            n_out.status = ST_OK;
        end

        // The last byte of a frame leaves the frame state cleared for the next one.
        if (frame_in.last_byte) begin
            n_byte_count    = '0;
            n_version_bad   = 1'b0;
            n_flags_held    = 8'd0;
            n_call_id_high  = 64'd0;
            n_call_id_low   = 64'd0;
            n_call_id_nz    = 1'b0;
            n_port_held     = 16'd0;
            n_host_len_held = 8'd0;
            n_host_char_bad = 1'b0;
        end else begin
            n_byte_count    = upd_byte_count;
            n_version_bad   = upd_version_bad;
            n_flags_held    = upd_flags_held;
            n_call_id_high  = upd_call_id_high;
            n_call_id_low   = upd_call_id_low;
            n_call_id_nz    = upd_call_id_nz;
            n_port_held     = upd_port_held;
            n_host_len_held = upd_host_len_held;
            n_host_char_bad = upd_host_char_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version   <= 8'd1;
            r_reserved_flag_mask <= 8'd0;
        end else if (i_cfg.valid) begin
            case (cfg_in.reg_index)
                REG_EXPECTED_VERSION:   r_expected_version   <= cfg_in.write_data;
                REG_RESERVED_FLAG_MASK: r_reserved_flag_mask <= cfg_in.write_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_version_bad   <= 1'b0;
            r_flags_held    <= 8'd0;
            r_call_id_high  <= 64'd0;
            r_call_id_low   <= 64'd0;
            r_call_id_nz    <= 1'b0;
            r_port_held     <= 16'd0;
            r_host_len_held <= 8'd0;
            r_host_char_bad <= 1'b0;
        end else if (frame_acc) begin
            r_byte_count    <= n_byte_count;
            r_version_bad   <= n_version_bad;
            r_flags_held    <= n_flags_held;
            r_call_id_high  <= n_call_id_high;
            r_call_id_low   <= n_call_id_low;
            r_call_id_nz    <= n_call_id_nz;
            r_port_held     <= n_port_held;
            r_host_len_held <= n_host_len_held;
            r_host_char_bad <= n_host_char_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frame_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_acc) begin
            r_out <= n_out;
        end
    end

endmodule

// File: sv/ifc_port_checker.sv
// Port-level checks on the invite frame checker, attached to the top level by bind.
// Depends on ifc_pkg and invite_frame_checker_defines.svh.
`include "invite_frame_checker_defines.svh"

module ifc_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ifc_pkg::t_frame_out i_out_payload
);
    import ifc_pkg::*;

    // A result that is not taken stays on offer unchanged.
    `IFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_payload), "result changed while stalled")

    // Each accepted byte shows its result in the following cycle.
    `IFC_ASSERT_NEXT(a_one_cycle, i_clk, i_rst_n, i_in_valid && i_in_ready,
        i_out_valid, "accepted byte gave no result on the next cycle")

    // An empty result register never holds back the input.
    `IFC_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready,
        "input stalled while no result was pending")

    // Verdict fields are zero on results that do not close a frame.
    `IFC_ASSERT_NOW(a_mid_frame, i_clk, i_rst_n, i_out_valid && !i_out_payload.frame_done,
        i_out_payload.status == ST_OK && i_out_payload.flag_bits == 8'd0 &&
        i_out_payload.port_number == 16'd0 && i_out_payload.host_length == 8'd0 &&
        i_out_payload.call_id_high == 64'd0 && i_out_payload.call_id_low == 64'd0,
        "header fields set on a result that does not close a frame")

    // Host echo fields are zero outside the host region.
    `IFC_ASSERT_NOW(a_non_host, i_clk, i_rst_n, i_out_valid && !i_out_payload.is_host,
        i_out_payload.host_char == 8'd0 && i_out_payload.host_position == 8'd0,
        "host echo set on a byte outside the host")

endmodule

bind invite_frame_checker ifc_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_frame.valid),
    .i_in_ready    (i_frame.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);
